/* src/ppa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared constants, codes, types and functions of the port pair allocator.
// ----------------------------------------------------------------------------
package ppa_pkg;

   localparam int POOL_PORTS = 1024;
   localparam int STAMP_BITS = 32;
   localparam int IDX_BITS   = $clog2(POOL_PORTS);
   localparam int PAIR_BITS  = IDX_BITS - 1;
   localparam int CNT_BITS   = IDX_BITS + 1;

   localparam logic [1:0] REQ_ACQUIRE = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_MARK    = 2'd2;
   localparam logic [1:0] REQ_TICK    = 2'd3;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_NO_PAIR  = 3'd1;
   localparam logic [2:0] ST_ODD      = 3'd2;
   localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
   localparam logic [2:0] ST_ZERO     = 3'd4;

   localparam logic [1:0] CSR_BASE     = 2'd0;
   localparam logic [1:0] CSR_COUNT    = 2'd1;
   localparam logic [1:0] CSR_LIFETIME = 2'd2;

   localparam logic [15:0] BASE_RESET     = 16'd10000;
   localparam logic [10:0] COUNT_RESET    = 11'd1024;
   localparam logic [31:0] LIFETIME_RESET = 32'd30000;

   // effective pool range
   typedef struct packed {
      logic [15:0]       start;
      logic [CNT_BITS-1:0] count;
      logic [16:0]       stop;
   } range_type;

   // per pair flags, index 0 is the even port
   typedef struct packed {
      logic       alloc;
      logic [1:0] mark;
      logic [1:0] used;
   } pair_type;

   function automatic range_type calc_range(input logic [15:0] base,
                                            input logic [10:0] cnt);
      range_type r;
      logic [16:0] c;
      logic [16:0] room;
      r.start = {base[15:1], 1'b0};
      room    = 17'h10000 - {1'b0, r.start};
      c       = {6'd0, cnt};
      if (c > 17'(POOL_PORTS)) c = 17'(POOL_PORTS);
      if (c > room) c = room;
      c[0]    = 1'b0;
      r.count = CNT_BITS'(c);
      r.stop  = {1'b0, r.start} + c;
      return r;
   endfunction

   // expiry test: (now - stamp) mod 2^STAMP_BITS >= lifetime
   function automatic logic stamp_expired(input logic [STAMP_BITS-1:0] now,
                                          input logic [STAMP_BITS-1:0] stamp,
                                          input logic [31:0] life);
      logic [STAMP_BITS-1:0] el;
      el = now - stamp;
      return {32'd0, el} >= {{STAMP_BITS{1'b0}}, life};
   endfunction

endpackage

/* src/port_pair_allocator_with_aging.sv */
`timescale 1ns / 1ps
// After the input transfer: tick, rejected release, mark outside the pool and acquire on
// an empty pool go straight to the result; mark reads the pair, then writes pair and stamp;
// release reads the pair, then answers not allocated or writes it back. Acquire sweeps all
// pool pairs for expiry, then tries pairs round robin from the pointer. One request in
// flight; a new input is taken once the result is accepted. Synchronous reset presets pointer,
// tick and CSRs, then a pair memory clearing pass holds req_ready low; stamps are not cleared.
// ----------------------------------------------------------------------------
// port_pair_allocator_with_aging
// Round robin even/odd port pair allocator with expiring occupied marks.
// ----------------------------------------------------------------------------
module port_pair_allocator_with_aging (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_req_type,
   input  logic [15:0] req_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_port_out,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import ppa_pkg::*;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_PRD0 = 4'd2;
   localparam logic [3:0] S_PRD1 = 4'd3;
   localparam logic [3:0] S_PCHK = 4'd4;
   localparam logic [3:0] S_SRD  = 4'd5;
   localparam logic [3:0] S_SCHK = 4'd6;
   localparam logic [3:0] S_RRD0 = 4'd7;
   localparam logic [3:0] S_RRD1 = 4'd8;
   localparam logic [3:0] S_RCHK = 4'd9;
   localparam logic [3:0] S_MRD  = 4'd10;
   localparam logic [3:0] S_MWR  = 4'd11;
   localparam logic [3:0] S_RESP = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic [15:0] base_ff;
   logic [10:0] count_ff;
   logic [31:0] life_ff;
   logic [15:0] next_ff, next_in;
   logic [STAMP_BITS-1:0] tick_ff, tick_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] cand_ff, cand_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic        exp_ff, exp_in;
   logic [15:0] out_port_ff, out_port_in;
   logic [2:0]  out_status_ff, out_status_in;

   logic                  st_we;
   logic [IDX_BITS-1:0]   st_addr;
   logic [STAMP_BITS-1:0] st_rd;
   logic                  expired;

   logic                  pair_we;
   logic [PAIR_BITS-1:0]  pair_addr;
   pair_type              pair_wd;
   pair_type              pw;

   range_type rng;

   ppa_stamp_ram #(.DEPTH(POOL_PORTS), .WIDTH(STAMP_BITS)) u_ram (
      .clock  (clock),
      .wr_en  (st_we),
      .addr   (st_addr),
      .wr_data(tick_ff),
      .rd_data(st_rd)
   );

   ppa_stamp_ram #(.DEPTH(POOL_PORTS/2), .WIDTH($bits(pair_type))) u_pair_ram (
      .clock  (clock),
      .wr_en  (pair_we),
      .addr   (pair_addr),
      .wr_data(pair_wd),
      .rd_data(pw)
   );

   assign rng      = calc_range(base_ff, count_ff);
   assign expired  = stamp_expired(tick_ff, st_rd, life_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_port_out = out_port_ff;
   assign rsp_status   = out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         count_ff <= COUNT_RESET;
         life_ff  <= LIFETIME_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE:     base_ff  <= csr_wr_data[15:0];
            CSR_COUNT:    count_ff <= csr_wr_data[10:0];
            CSR_LIFETIME: life_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [16:0] p;
      logic [IDX_BITS-1:0] i;
      logic [16:0] portx;
      pair_type nw;
      state_in = state_ff;
      next_in  = next_ff;
      tick_in  = tick_ff;
      op_in    = op_ff;
      cand_in  = cand_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      exp_in   = exp_ff;
      out_port_in   = out_port_ff;
      out_status_in = out_status_ff;
      pair_we   = 1'b0;
      pair_addr = idx_ff[IDX_BITS-1:1];
      pair_wd   = '0;
      st_we     = 1'b0;
      st_addr   = {idx_ff[IDX_BITS-1:1], 1'b0};
      p = '0;
      i = '0;
      portx = {1'b0, req_port};
      nw = pw;
      unique case (state_ff)
         S_CLR: begin
            pair_we = 1'b1;
            if (idx_ff == IDX_BITS'(POOL_PORTS - 2)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_BITS'(2);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_req_type;
               out_port_in   = '0;
               out_status_in = ST_DONE;
               idx_in = '0;
               cnt_in = '0;
               unique case (req_req_type)
                  REQ_ACQUIRE: begin
                     if (rng.count == '0) begin
                        out_status_in = ST_NO_PAIR;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_PRD0;
                     end
                  end
                  REQ_RELEASE: begin
                     priority if (req_port == 16'd0) begin
                        out_status_in = ST_ZERO;
                        state_in = S_RESP;
                     end else if (req_port[0]) begin
                        out_status_in = ST_ODD;
                        state_in = S_RESP;
                     end else if (req_port < rng.start || portx >= rng.stop) begin
                        out_status_in = ST_NOT_ALLOC;
                        state_in = S_RESP;
                     end else begin
                        idx_in   = IDX_BITS'(req_port - rng.start);
                        state_in = S_RRD0;
                     end
                  end
                  REQ_MARK: begin
                     if (req_port >= rng.start && portx < rng.stop) begin
                        idx_in   = IDX_BITS'(req_port - rng.start);
                        state_in = S_MRD;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     tick_in  = tick_ff + 1'b1;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_PRD0: begin
            state_in = S_PRD1;
         end
         S_PRD1: begin
            // even stamp on the read port, odd stamp issued
            st_addr  = {idx_ff[IDX_BITS-1:1], 1'b1};
            exp_in   = pw.mark[0] && expired;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (exp_ff) begin
               if (!pw.alloc) nw.used[0] = 1'b0;
               nw.mark[0] = 1'b0;
            end
            if (pw.mark[1] && expired) begin
               if (!pw.alloc) nw.used[1] = 1'b0;
               nw.mark[1] = 1'b0;
            end
            pair_we = 1'b1;
            pair_wd = nw;
            if ({1'b0, idx_ff} == rng.count - CNT_BITS'(2)) begin
               cnt_in   = '0;
               state_in = S_SRD;
            end else begin
               idx_in   = idx_ff + IDX_BITS'(2);
               state_in = S_PRD0;
            end
         end
         S_SRD: begin
            p = {1'b0, next_ff};
            if (next_ff < rng.start || p >= rng.stop) p = {1'b0, rng.start};
            if (p[0]) p = p + 17'd1;
            if (p >= rng.stop) p = {1'b0, rng.start};
            next_in = ((p + 17'd2) >= rng.stop) ? rng.start : 16'(p + 17'd2);
            i = IDX_BITS'(p[15:0] - rng.start);
            cand_in   = p[15:0];
            idx_in    = i;
            pair_addr = i[IDX_BITS-1:1];
            state_in  = S_SCHK;
         end
         S_SCHK: begin
            if (!pw.used[0] && !pw.used[1]) begin
               nw.used  = 2'b11;
               nw.alloc = 1'b1;
               pair_we  = 1'b1;
               pair_wd  = nw;
               out_port_in = cand_ff;
               state_in = S_RESP;
            end else if (cnt_ff + CNT_BITS'(1) >= {1'b0, rng.count[CNT_BITS-1:1]}) begin
               out_status_in = ST_NO_PAIR;
               state_in = S_RESP;
            end else begin
               cnt_in   = cnt_ff + CNT_BITS'(1);
               state_in = S_SRD;
            end
         end
         S_RRD0: begin
            state_in = S_RRD1;
         end
         S_RRD1: begin
            st_addr = {idx_ff[IDX_BITS-1:1], 1'b1};
            if (!pw.alloc) begin
               out_status_in = ST_NOT_ALLOC;
               state_in = S_RESP;
            end else begin
               exp_in   = pw.mark[0] && expired;
               state_in = S_RCHK;
            end
         end
         S_RCHK: begin
            // a half keeps used only while its mark is live
            nw.alloc   = 1'b0;
            nw.used[0] = pw.mark[0] && !exp_ff;
            nw.mark[0] = pw.mark[0] && !exp_ff;
            nw.used[1] = pw.mark[1] && !expired;
            nw.mark[1] = pw.mark[1] && !expired;
            pair_we  = 1'b1;
            pair_wd  = nw;
            state_in = S_RESP;
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            nw.used[idx_ff[0]] = 1'b1;
            nw.mark[idx_ff[0]] = 1'b1;
            pair_we  = 1'b1;
            pair_wd  = nw;
            st_we    = 1'b1;
            st_addr  = idx_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= '0;
         next_ff  <= BASE_RESET;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         next_ff  <= next_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cand_ff <= cand_in;
      cnt_ff  <= cnt_in;
      exp_ff  <= exp_in;
      out_port_ff   <= out_port_in;
      out_status_ff <= out_status_in;
   end

`ifndef SYNTHESIS
   a_grant_even: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DONE && op_ff == REQ_ACQUIRE) |-> !rsp_port_out[0])
      else $error("odd port granted");
   a_nonacq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && op_ff != REQ_ACQUIRE) |-> rsp_port_out == 16'd0)
      else $error("port on non acquire");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_port_out) && $stable(rsp_status)))
      else $error("result changed while waiting");
   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(tick_ff))
      else $error("tick moved while busy");
`endif
endmodule

/* src/ppa_stamp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_stamp_ram
// Single port memory for stamps and pair flags, registered read data.
// ----------------------------------------------------------------------------
module ppa_stamp_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* test/port_pair_allocator_with_aging_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_pair_allocator_with_aging_tb
// Self-checking bench: directed rows, then mixed random traffic with marks,
// ticks and several pool settings, checked against a behavioral pair model.
// ----------------------------------------------------------------------------
module port_pair_allocator_with_aging_tb;
   import ppa_pkg::*;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] port;
      logic        known;
      logic [15:0] port_exp;
      logic [2:0]  st_exp;
   } stim_row_type;

   typedef struct {
      logic [15:0] port_out;
      logic [2:0]  status;
   } grant_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_req_type;
   logic [15:0] req_port;
   logic        rsp_valid, rsp_ready;
   logic [15:0] rsp_port_out;
   logic [2:0]  rsp_status;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wr_data;

   port_pair_allocator_with_aging i_dut (.*);

   // allocator model state
   logic [15:0] m_base;
   logic [10:0] m_count;
   logic [31:0] m_life;
   logic        m_used[POOL_PORTS];
   logic        m_alloc[POOL_PORTS/2];
   logic        m_mark[POOL_PORTS];
   logic [31:0] m_stamp[POOL_PORTS];
   logic [15:0] m_next;
   logic [31:0] m_tick;

   grant_type   grant_q[$];
   int          errors, n_rsp, n_grant, n_nopair;
   logic        hold_off;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("Verification failed");
      $finish;
   end

   function automatic int eff_count();
      int s, c;
      s = m_base & 16'hFFFE;
      c = m_count;
      if (c > POOL_PORTS) c = POOL_PORTS;
      if (c > 65536 - s) c = 65536 - s;
      return c & ~1;
   endfunction

   function automatic logic mark_alive(int i);
      logic [31:0] el;
      el = m_tick - m_stamp[i];
      return el < m_life;
   endfunction

   function automatic grant_type predict_grant(logic [1:0] op, logic [15:0] port);
      grant_type g;
      int s, c, e, p, i, pi;
      logic done;
      g.port_out = '0;
      g.status = ST_DONE;
      s = m_base & 16'hFFFE;
      c = eff_count();
      e = s + c;
      case (op)
         REQ_ACQUIRE: begin
            for (i = 0; i < c; i++)
               if (m_mark[i] && !mark_alive(i)) begin
                  if (!m_alloc[i >> 1]) m_used[i] = 1'b0;
                  m_mark[i] = 1'b0;
               end
            g.status = ST_NO_PAIR;
            done = 1'b0;
            for (int t = 0; t < c / 2 && !done; t++) begin
               p = m_next;
               if (p < s || p >= e) p = s;
               if (p & 1) p++;
               if (p >= e) p = s;
               m_next = (p + 2 >= e) ? s : p + 2;
               i = p - s;
               if (!m_used[i] && !m_used[i+1]) begin
                  m_used[i] = 1'b1;
                  m_used[i+1] = 1'b1;
                  m_alloc[i >> 1] = 1'b1;
                  g.status = ST_DONE;
                  g.port_out = p;
                  done = 1'b1;
               end
            end
         end
         REQ_RELEASE: begin
            if (port == 0) g.status = ST_ZERO;
            else if (port[0]) g.status = ST_ODD;
            else if (port < s || port >= e) g.status = ST_NOT_ALLOC;
            else begin
               i = port - s;
               pi = i >> 1;
               if (!m_alloc[pi]) g.status = ST_NOT_ALLOC;
               else begin
                  m_alloc[pi] = 1'b0;
                  for (int k = i; k <= i + 1; k++) begin
                     m_used[k] = 1'b0;
                     if (m_mark[k]) begin
                        if (mark_alive(k)) m_used[k] = 1'b1;
                        else m_mark[k] = 1'b0;
                     end
                  end
               end
            end
         end
         REQ_MARK: begin
            if (port >= s && port < e) begin
               i = port - s;
               m_used[i] = 1'b1;
               m_mark[i] = 1'b1;
               m_stamp[i] = m_tick;
            end
         end
         default: m_tick = m_tick + 1;
      endcase
      return g;
   endfunction

   // result side: checks and stall pattern
   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (rsp_status == ST_DONE && rsp_port_out != 0) n_grant++;
         if (rsp_status == ST_NO_PAIR) n_nopair++;
         if (grant_q.size() == 0) begin
            $display("%t unexpected transfer port_out=%0d status=%0d", $time,
                     rsp_port_out, rsp_status);
            errors++;
         end else begin
            g = grant_q.pop_front();
            if (rsp_port_out !== g.port_out) begin
               $display("%t port_out expected %0d actual %0d", $time, g.port_out,
                        rsp_port_out);
               errors++;
            end
            if (rsp_status !== g.status) begin
               $display("%t status expected %0d actual %0d", $time, g.status,
                        rsp_status);
               errors++;
            end
         end
      end
      rsp_ready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_BASE:  m_base  = data[15:0];
         CSR_COUNT: m_count = data[10:0];
         default:   m_life  = data;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (grant_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one transfer; the gap count comes from the caller, zero keeps valid high
   task automatic send_req(logic [1:0] op, logic [15:0] port, int gap);
      grant_type g;
      req_valid    <= 1'b1;
      req_req_type <= op;
      req_port     <= port;
      do @(posedge clock); while (!req_ready);
      g = predict_grant(op, port);
      grant_q.push_back(g);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_burst(int n);
      int blen, op;
      logic [15:0] p;
      int s, c;
      blen = 0;
      for (int k = 0; k < n; k++) begin
         s = m_base & 16'hFFFE;
         c = eff_count();
         op = $urandom_range(0, 9);
         if (op < 3) op = REQ_ACQUIRE;
         else if (op < 6) op = REQ_RELEASE;
         else if (op < 8) op = REQ_MARK;
         else op = REQ_TICK;
         if ($urandom_range(0, 5) == 0 || c == 0) p = $urandom;
         else begin
            p = s + $urandom_range(0, c - 1);
            if (op == REQ_RELEASE && $urandom_range(0, 5) != 0) p[0] = 1'b0;
         end
         if (blen == 0) blen = $urandom_range(1, 12);
         blen--;
         send_req(op[1:0], p, (blen == 0) ? $urandom_range(1, 6) : 0);
      end
      req_valid <= 1'b0;
   endtask

   stim_row_type rows[$];

   initial begin
      grant_type g;
      req_valid = 1'b0; req_req_type = '0; req_port = '0;
      rsp_ready = 1'b0; hold_off = 1'b0;
      csr_wr_en = 1'b0; csr_index = '0; csr_wr_data = '0;
      errors = 0; n_rsp = 0; n_grant = 0; n_nopair = 0;
      m_base = BASE_RESET; m_count = COUNT_RESET; m_life = LIFETIME_RESET;
      for (int i = 0; i < POOL_PORTS; i++) begin
         m_used[i] = 0; m_mark[i] = 0; m_stamp[i] = 0;
      end
      for (int i = 0; i < POOL_PORTS / 2; i++) m_alloc[i] = 0;
      m_next = BASE_RESET; m_tick = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset settings, then a tiny pool
      rows = '{
         '{REQ_ACQUIRE, 16'd0,     1, 16'd10000, ST_DONE},
         '{REQ_ACQUIRE, 16'd0,     1, 16'd10002, ST_DONE},
         '{REQ_RELEASE, 16'd0,     1, 16'd0,     ST_ZERO},
         '{REQ_RELEASE, 16'd10001, 1, 16'd0,     ST_ODD},
         '{REQ_RELEASE, 16'hFFFF,  1, 16'd0,     ST_ODD},
         '{REQ_RELEASE, 16'd10004, 1, 16'd0,     ST_NOT_ALLOC},
         '{REQ_RELEASE, 16'hFFFE,  1, 16'd0,     ST_NOT_ALLOC},
         '{REQ_RELEASE, 16'd10000, 1, 16'd0,     ST_DONE},
         '{REQ_RELEASE, 16'd10000, 1, 16'd0,     ST_NOT_ALLOC},
         '{REQ_MARK,    16'd0,     1, 16'd0,     ST_DONE},
         '{REQ_MARK,    16'd10004, 1, 16'd0,     ST_DONE},
         '{REQ_TICK,    16'hFFFF,  1, 16'd0,     ST_DONE},
         '{REQ_ACQUIRE, 16'd0,     0, 16'd0,     ST_DONE},
         '{REQ_MARK,    16'd10006, 0, 16'd0,     ST_DONE},
         '{REQ_RELEASE, 16'd10002, 0, 16'd0,     ST_DONE}
      };
      foreach (rows[r]) begin
         send_req(rows[r].op, rows[r].port, 1);
         if (rows[r].known) begin
            g = grant_q[$];
            if (g.port_out !== rows[r].port_exp || g.status !== rows[r].st_exp) begin
               $display("%t row %0d model expected %0d/%0d actual %0d/%0d", $time, r,
                        rows[r].port_exp, rows[r].st_exp, g.port_out, g.status);
               errors++;
            end
         end
      end
      wait_drained();

      // tiny pool with short marks: fill, expire, wrap of the pointer
      csr_write(CSR_BASE, 32'd65533);
      csr_write(CSR_COUNT, 32'd4);
      csr_write(CSR_LIFETIME, 32'd1);
      send_req(REQ_MARK, 16'd65534, 1);
      send_req(REQ_ACQUIRE, 16'd0, 1);
      send_req(REQ_ACQUIRE, 16'd0, 1);
      send_req(REQ_TICK, 16'd0, 1);
      send_req(REQ_ACQUIRE, 16'd0, 1);
      send_req(REQ_RELEASE, 16'd65534, 1);
      send_req(REQ_RELEASE, 16'd65532, 1);
      wait_drained();

      csr_write(CSR_COUNT, 32'd2);
      csr_write(CSR_LIFETIME, 32'hFFFF_FFFF);
      random_burst(40);
      wait_drained();

      // long receiver hold-off so the block backs up its input
      csr_write(CSR_BASE, 32'd1);
      csr_write(CSR_COUNT, 32'd16);
      csr_write(CSR_LIFETIME, 32'd3);
      hold_off = 1'b1;
      fork
         begin
            for (int k = 0; k < 300; k++) @(posedge clock);
            hold_off = 1'b0;
         end
         random_burst(60);
      join
      wait_drained();

      csr_write(CSR_BASE, 32'd64000);
      csr_write(CSR_COUNT, 32'd2047);
      csr_write(CSR_LIFETIME, 32'd5);
      random_burst(50);
      wait_drained();

      csr_write(CSR_BASE, 32'd10000);
      csr_write(CSR_COUNT, 32'd1024);
      csr_write(CSR_LIFETIME, 32'd8);
      random_burst(60);
      wait_drained();

      csr_write(CSR_BASE, 32'd200);
      csr_write(CSR_COUNT, 32'd24);
      csr_write(CSR_LIFETIME, 32'd2);
      random_burst(60);
      wait_drained();

      $display("Covered %0d transfers: %0d grants, %0d pool-full answers,", n_rsp,
               n_grant, n_nopair);
      $display("release/mark/tick traffic over six pool settings incl. top of range.");
      if (errors == 0 && grant_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/ppa_pkg.sv
src/ppa_stamp_ram.sv
src/port_pair_allocator_with_aging.sv
test/port_pair_allocator_with_aging_tb.sv
